// File: hdl/rgbhsl_pkg.sv
// shared types and constants for the rgb to hsl conversion core
`default_nettype none
package rgbhsl_pkg;

    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int HUE_W       = 9;
    localparam int PCT_W       = 7;
    localparam int OUT_DATA_W  = 24;

    // hue in thousandths of a sextant, 0..6000
    localparam int HUE_TH_W    = 13;
    localparam int HUE_NUM_W   = 18;
    localparam int HUE_QBITS   = 10;
    localparam int SAT_NUM_W   = 15;
    localparam int SAT_QBITS   = 7;
    localparam int NUM_STG     = HUE_QBITS;

    localparam int LIGHT_X_W   = 15;
    localparam int HUE_X_W     = 16;
    localparam int HUE_PROD_W  = HUE_X_W + 13;
    localparam int RECIP_SHIFT = 19;

    localparam logic [9:0]  HUE_SCALE   = 10'd1000;
    localparam logic [6:0]  SAT_SCALE   = 7'd100;
    localparam logic [5:0]  LIGHT_SCALE = 6'd50;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [2:0]  HUE_MUL     = 3'd6;

    localparam logic [HUE_TH_W-1:0] BASE_RED     = 13'd0;
    localparam logic [HUE_TH_W-1:0] BASE_GREEN   = 13'd2000;
    localparam logic [HUE_TH_W-1:0] BASE_BLUE    = 13'd4000;
    localparam logic [HUE_TH_W-1:0] BASE_RED_NEG = 13'd6000;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // classified pixel, as passed from front to back
    typedef struct packed {
        logic                 grey;
        logic                 neg;
        logic [HUE_TH_W-1:0]  base;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [CHAN_W-1:0]    d;
        logic [CHAN_W-1:0]    mx;
        logic [PCT_W-1:0]     light;
    } t_item;

    // divider pipeline stage contents
    typedef struct packed {
        logic                 grey;
        logic                 neg;
        logic [HUE_TH_W-1:0]  base;
        logic [HUE_NUM_W-1:0] hrem;
        logic [HUE_QBITS-1:0] hq;
        logic [SAT_NUM_W-1:0] srem;
        logic [SAT_QBITS-1:0] sq;
        logic [CHAN_W-1:0]    d;
        logic [CHAN_W-1:0]    mx;
        logic [PCT_W-1:0]     light;
    } t_div;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage
`default_nettype wire

// File: hdl/rgbhsl_front.sv
// front end: takes pixels, finds max, min and hue sextant, computes lightness
`default_nettype none
module rgbhsl_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rgbhsl_pkg::PIXEL_W-1:0] i_pixel,
    output rgbhsl_pkg::t_push                   o_push,
    input  wire logic                           i_full
);
    import rgbhsl_pkg::*;

    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic [CHAN_W-1:0]  r, g, b, mx, mn;
    logic [CHAN_W-1:0]  diff;
    logic [LIGHT_X_W-1:0] light_x;
    logic [LIGHT_X_W:0]   light_t;
    logic [LIGHT_X_W:0]   light_s;
    logic               push;

    assign push    = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;

    always_comb begin
        r  = i_pixel[3*CHAN_W-1:2*CHAN_W];
        g  = i_pixel[2*CHAN_W-1:CHAN_W];
        b  = i_pixel[CHAN_W-1:0];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;

        n_item      = '0;
        n_item.grey = (mx == mn);
        n_item.d    = mx - mn;
        n_item.mx   = mx;

        // red, green, blue priority on ties
        if (mx == r) begin
            n_item.neg  = (g < b);
            diff        = n_item.neg ? b - g : g - b;
            n_item.base = n_item.neg ? BASE_RED_NEG : BASE_RED;
        end else if (mx == g) begin
            n_item.neg  = (b < r);
            diff        = n_item.neg ? r - b : b - r;
            n_item.base = BASE_GREEN;
        end else begin
            n_item.neg  = (r < g);
            diff        = n_item.neg ? g - r : r - g;
            n_item.base = BASE_BLUE;
        end
        n_item.hue_num = HUE_NUM_W'(diff) * HUE_NUM_W'(HUE_SCALE);
        n_item.sat_num = SAT_NUM_W'(n_item.d) * SAT_NUM_W'(SAT_SCALE);

        // divide by 255 through (t + t/256) / 256 with t = x + 1
        light_x      = (LIGHT_X_W'(mx) + LIGHT_X_W'(mn)) * LIGHT_X_W'(LIGHT_SCALE);
        light_t      = (LIGHT_X_W+1)'(light_x) + 1'b1;
        light_s      = light_t + (light_t >> 8);
        n_item.light = light_s[PCT_W+7:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_push = '{valid: push, item: r_item};

endmodule
`default_nettype wire

// File: hdl/rgbhsl_fifo.sv
// short queue between front and back
`default_nettype none
module rgbhsl_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rgbhsl_pkg::t_push i_push,
    output logic                   o_full,
    output logic                   o_empty,
    output rgbhsl_pkg::t_item      o_head,
    input  wire logic              i_pop
);
    import rgbhsl_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push.valid && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/rgbhsl_back.sv
// back end: pipelined dividers for hue and saturation, hue scaling, output register
`default_nettype none
module rgbhsl_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire rgbhsl_pkg::t_item           i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rgbhsl_pkg::OUT_DATA_W-1:0] o_data
);
    import rgbhsl_pkg::*;

    // one hue quotient bit per stage; one saturation quotient bit only in the stages for its SAT_QBITS low bits
    function automatic t_div div_step(input t_div s, input logic [3:0] hb);
        t_div                 o;
        logic [HUE_NUM_W-1:0] hs;
        logic [SAT_NUM_W-1:0] ss;
        o  = s;
        hs = HUE_NUM_W'(s.d) << hb;
        if (s.hrem >= hs) begin
            o.hrem   = s.hrem - hs;
            o.hq[hb] = 1'b1;
        end
        if (hb < 4'(SAT_QBITS)) begin
            ss = SAT_NUM_W'(s.mx) << hb;
            if (s.srem >= ss) begin
                o.srem        = s.srem - ss;
                o.sq[hb[2:0]] = 1'b1;
            end
        end
        return o;
    endfunction

    logic                  adv;
    logic                  r_sv [NUM_STG];
    t_div                  r_st [NUM_STG];
    t_div                  stg_in [NUM_STG];
    logic                  r_hv;
    logic [HUE_TH_W-1:0]   r_hue_th;
    logic [SAT_QBITS-1:0]  r_h_sat;
    logic [PCT_W-1:0]      r_h_light;
    logic [HUE_TH_W-1:0]   hue_th;
    logic [HUE_X_W-1:0]    hue_x;
    logic [HUE_PROD_W-1:0] hue_prod;
    logic                  r_ov;
    logic [HUE_W-1:0]      r_hue;
    logic [PCT_W-1:0]      r_sat;
    logic [PCT_W-1:0]      r_light;

    // whole pipeline moves together when the output slot frees up
    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && !i_empty;

    always_comb begin
        stg_in[0]       = '0;
        stg_in[0].grey  = i_head.grey;
        stg_in[0].neg   = i_head.neg;
        stg_in[0].base  = i_head.base;
        stg_in[0].hrem  = i_head.hue_num;
        stg_in[0].srem  = i_head.sat_num;
        stg_in[0].d     = i_head.d;
        stg_in[0].mx    = i_head.mx;
        stg_in[0].light = i_head.light;
    end

    for (genvar j = 0; j < NUM_STG; j++) begin : g_stg
        if (j > 0) begin : g_link
            assign stg_in[j] = r_st[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (adv) begin
                r_sv[j] <= (j == 0) ? !i_empty : r_sv[(j == 0) ? 0 : j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[j] <= div_step(stg_in[j], 4'(HUE_QBITS-1-j));
            end
        end
    end

    // hue in thousandths of a sextant
    always_comb begin
        if (r_st[NUM_STG-1].neg) begin
            hue_th = r_st[NUM_STG-1].base - HUE_TH_W'(r_st[NUM_STG-1].hq);
        end else begin
            hue_th = r_st[NUM_STG-1].base + HUE_TH_W'(r_st[NUM_STG-1].hq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (adv) begin
            r_hv <= r_sv[NUM_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hue_th  <= r_st[NUM_STG-1].grey ? '0 : hue_th;
            r_h_sat   <= r_st[NUM_STG-1].grey ? '0 : r_st[NUM_STG-1].sq;
            r_h_light <= r_st[NUM_STG-1].light;
        end
    end

    // degrees = hue_th * 6 / 100, divide by reciprocal multiply
    assign hue_x    = HUE_X_W'(r_hue_th) * HUE_X_W'(HUE_MUL);
    assign hue_prod = HUE_PROD_W'(hue_x) * HUE_PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hue   <= hue_prod[RECIP_SHIFT+HUE_W-1:RECIP_SHIFT];
            r_sat   <= r_h_sat;
            r_light <= r_h_light;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = {(OUT_DATA_W-HUE_W-2*PCT_W)'(0), r_light, r_sat, r_hue};

endmodule
`default_nettype wire

// File: hdl/rgb_to_hsl_integer_core.sv
// top level of the rgb to hsl conversion core
// path: a pixel passes the front register, the queue, the divider stages, the hue register and the output register
// throughput: one pixel per cycle while m_axis_tready is high, set by the 10-stage restoring divider pipeline
// the 4-entry queue lets the front keep taking pixels while the output stalls, until the queue fills
// reset: synchronous, active low; clears all valid flags and queue pointers
// payload registers are not reset
`default_nettype none
module rgb_to_hsl_integer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input pixel stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] color_word
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [8:0] hue_degrees, [15:9] saturation_pct,
                                             // [22:16] lightness_pct, [23] zero
);
    import rgbhsl_pkg::*;

    t_push push;
    t_item head;
    logic  full;
    logic  empty;
    logic  pop;

    // front: channel compare, sextant pick, numerators and lightness
    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata),
        .o_push  (push),
        .i_full  (full)
    );

    // decouples front from the stallable back end
    rgbhsl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back: both divisions bit by bit, then hue scaling to degrees
    rgbhsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: hdl/rgbhsl_checker.sv
// port-level checks for the rgb to hsl conversion core, bound to the top level
`default_nettype none
module rgbhsl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // a stalled result transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:0] < 9'd360)
        else $error("hue out of range");

    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] <= 7'd100 && m_axis_tdata[22:16] <= 7'd100
            && !m_axis_tdata[23])
        else $error("percent out of range");

endmodule

bind rgb_to_hsl_integer_core rgbhsl_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
